[rtl/tsw_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsw_pkg: shared types and constants of the thread stall watchdog
// Operation codes, watch states, report codes, register indexes and the
// structs that pass between the front end, the back end and the top level.
// ----------------------------------------------------------------------------
package tsw_pkg;

    localparam int DEF_QUEUE_DEPTH = 16;

    localparam int STAMP_W  = 64;
    localparam int CNT_W    = 31;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W    = 32;
    localparam int S_TDATA_W = 128;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 16;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    localparam logic [31:0] RST_FREEZE_TIME   = 32'd5000;
    localparam logic [7:0]  RST_DIALOG_BLOCK  = 8'd20;
    localparam logic [3:0]  RST_REPORT_EVERY  = 4'd5;
    localparam logic [7:0]  RST_NORMAL_PERIOD = 8'd3;
    localparam logic [7:0]  RST_WARN_PERIOD   = 8'd2;
    localparam logic [7:0]  RST_FREEZE_PERIOD = 8'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FREEZE_TIME   = 3'd0,
        REG_DIALOG_BLOCK  = 3'd1,
        REG_REPORT_EVERY  = 3'd2,
        REG_NORMAL_PERIOD = 3'd3,
        REG_WARN_PERIOD   = 3'd4,
        REG_FREEZE_PERIOD = 3'd5
    } reg_idx_t;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_BEAT   = 2'd1,
        OP_BURY   = 2'd2,
        OP_DEFUSE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_NORMAL  = 2'd0,
        ST_WARNING = 2'd1,
        ST_FREEZE  = 2'd2
    } watch_t;

    typedef enum logic [1:0] {
        REP_NONE    = 2'd0,
        REP_WARNING = 2'd1,
        REP_FREEZE  = 2'd2,
        REP_RECOVER = 2'd3
    } report_t;

    // The argument is the bury stamp for OP_BURY and the current time otherwise.
    typedef struct packed {
        op_t                op;
        logic [STAMP_W-1:0] arg;
    } item_t;

    typedef struct packed {
        report_t    report;
        logic       show_dialog;
        logic       ping_thread;
        logic [7:0] next_period_s;
        logic       stuck;
        logic       bomb_dropped;
    } result_t;

endpackage

[rtl/tsw_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsw_front: input decode and item queue
// Classifies each input beat into an operation with a single argument and
// holds it in a two-entry queue until the back end takes it.
// ----------------------------------------------------------------------------
module tsw_front
    import tsw_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [1:0]         func,
    input  logic [STAMP_W-1:0] bomb_stamp_ms,
    input  logic [STAMP_W-1:0] now_ms,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               q_valid,
    output item_t              q_item,
    input  logic               q_pop
);

    item_t       entry_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        push;
    item_t       dec_item;

    always_comb
    begin
        dec_item.arg = now_ms;
        case (func)
            2'd0:
            begin
                dec_item.op = OP_TICK;
            end
            2'd1:
            begin
                dec_item.op = OP_BEAT;
            end
            2'd2:
            begin
                dec_item.op  = OP_BURY;
                dec_item.arg = bomb_stamp_ms;
            end
            default:
            begin
                dec_item.op = OP_DEFUSE;
            end
        endcase
    end

    assign in_ready = (count_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ q_pop;
        count_next  = count_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= dec_item;
        end
    end

`ifndef SYNTH
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("item queue count out of range");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> count_reg != 2'd0)
        else $error("pop from empty item queue");
    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !q_pop) |=> count_reg == $past(count_reg) + 2'd1)
        else $error("item queue count did not follow a push");
`endif

endmodule

[rtl/tsw_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsw_back: watch state machine, timestamp FIFO and result register
// Executes one queued operation per cycle unless a held result stalls it, keeps
// the ping and heartbeat counters, the escalation state and the timestamp
// memory, and holds the result until the receiver takes it.
// ----------------------------------------------------------------------------
module tsw_back
    import tsw_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 q_valid,
    input  item_t                q_item,
    output logic                 q_pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output result_t              out_result
);

    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W  = PTR_W + 1;
    localparam logic [SUM_W-1:0]  DEPTH_S    = SUM_W'(QUEUE_DEPTH);
    localparam logic [FILL_W-1:0] DEPTH_F    = FILL_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0]  LAST_ENTRY = PTR_W'(QUEUE_DEPTH - 1);

    logic [31:0]        freeze_time_reg;
    logic [7:0]         dialog_block_reg;
    logic [3:0]         report_every_reg;
    logic [7:0]         normal_period_reg;
    logic [7:0]         warn_period_reg;
    logic [7:0]         freeze_period_reg;

    logic [CNT_W-1:0]   ping_reg;
    logic [CNT_W-1:0]   ping_next;
    logic [CNT_W-1:0]   beat_reg;
    logic [CNT_W-1:0]   beat_next;
    watch_t             state_reg;
    watch_t             state_next;
    logic [3:0]         freeze_checks_reg;
    logic [3:0]         freeze_checks_next;
    logic               allowed_reg;
    logic               allowed_next;
    logic [7:0]         block_cnt_reg;
    logic [7:0]         block_cnt_next;
    logic [PTR_W-1:0]   head_reg;
    logic [PTR_W-1:0]   head_next;
    logic [FILL_W-1:0]  fill_reg;
    logic [FILL_W-1:0]  fill_next;

    logic [STAMP_W-1:0] stamp_mem [QUEUE_DEPTH];
    logic [STAMP_W-1:0] head_data_reg;
    logic               mem_we;
    logic [SUM_W-1:0]   tail_sum;
    logic [PTR_W-1:0]   tail_addr;

    logic               out_valid_reg;
    result_t            out_result_reg;
    result_t            res;
    logic               fire;
    logic               age_check;
    logic               expired;
    logic [7:0]         block_inc;
    logic [3:0]         checks_inc;

    assign q_pop      = fire;
    assign fire       = q_valid && (!out_valid_reg || out_ready);
    assign out_valid  = out_valid_reg;
    assign out_result = out_result_reg;

    assign tail_sum  = SUM_W'(head_reg) + SUM_W'(fill_reg);
    assign tail_addr = (tail_sum >= DEPTH_S) ? PTR_W'(tail_sum - DEPTH_S) : PTR_W'(tail_sum);
    assign expired   = (q_item.arg - head_data_reg) > {32'd0, freeze_time_reg};
    assign block_inc = block_cnt_reg + 8'd1;
    assign checks_inc = freeze_checks_reg + 4'd1;

    always_comb
    begin
        ping_next          = ping_reg;
        beat_next          = beat_reg;
        state_next         = state_reg;
        freeze_checks_next = freeze_checks_reg;
        allowed_next       = allowed_reg;
        block_cnt_next     = block_cnt_reg;
        head_next          = head_reg;
        fill_next          = fill_reg;
        mem_we             = 1'b0;
        age_check          = 1'b0;
        res                = '0;
        if (fire)
        begin
            case (q_item.op)
                OP_TICK:
                begin
                    res.stuck       = (ping_reg != beat_reg);
                    res.ping_thread = 1'b1;
                    res.next_period_s = normal_period_reg;
                    if (ping_reg == CNT_MAX)
                    begin
                        ping_next = CNT_W'(1);
                        beat_next = '0;
                    end
                    else
                    begin
                        ping_next = ping_reg + CNT_W'(1);
                    end
                    if (!res.stuck)
                    begin
                        if (state_reg == ST_FREEZE)
                        begin
                            res.report = REP_RECOVER;
                        end
                        freeze_checks_next = 4'd0;
                        state_next         = ST_NORMAL;
                        allowed_next       = 1'b1;
                        block_cnt_next     = 8'd0;
                    end
                    else
                    begin
                        case (state_reg)
                            ST_NORMAL:
                            begin
                                res.report        = REP_WARNING;
                                state_next        = ST_WARNING;
                                res.next_period_s = warn_period_reg;
                            end
                            ST_WARNING:
                            begin
                                res.report        = REP_FREEZE;
                                state_next        = ST_FREEZE;
                                res.next_period_s = freeze_period_reg;
                                age_check         = 1'b1;
                            end
                            default:
                            begin
                                state_next = ST_FREEZE;
                                if (!allowed_reg)
                                begin
                                    block_cnt_next = block_inc;
                                    if (block_inc >= dialog_block_reg)
                                    begin
                                        allowed_next   = 1'b1;
                                        block_cnt_next = 8'd0;
                                    end
                                end
                                freeze_checks_next = checks_inc;
                                if (checks_inc >= report_every_reg)
                                begin
                                    res.report         = REP_FREEZE;
                                    freeze_checks_next = 4'd0;
                                end
                                res.next_period_s = freeze_period_reg;
                                age_check         = 1'b1;
                            end
                        endcase
                        if (age_check && (fill_reg != '0) && expired)
                        begin
                            if (allowed_next)
                            begin
                                res.show_dialog = 1'b1;
                                allowed_next    = 1'b0;
                                block_cnt_next  = 8'd0;
                            end
                            fill_next = '0;
                            head_next = '0;
                        end
                    end
                end
                OP_BEAT:
                begin
                    beat_next = beat_reg + CNT_W'(1);
                end
                OP_BURY:
                begin
                    if (fill_reg == DEPTH_F)
                    begin
                        res.bomb_dropped = 1'b1;
                    end
                    else
                    begin
                        mem_we    = 1'b1;
                        fill_next = fill_reg + FILL_W'(1);
                    end
                end
                default:
                begin
                    if (fill_reg != '0)
                    begin
                        head_next = (head_reg == LAST_ENTRY) ? '0 : head_reg + PTR_W'(1);
                        fill_next = fill_reg - FILL_W'(1);
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            freeze_time_reg   <= RST_FREEZE_TIME;
            dialog_block_reg  <= RST_DIALOG_BLOCK;
            report_every_reg  <= RST_REPORT_EVERY;
            normal_period_reg <= RST_NORMAL_PERIOD;
            warn_period_reg   <= RST_WARN_PERIOD;
            freeze_period_reg <= RST_FREEZE_PERIOD;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_FREEZE_TIME:   freeze_time_reg   <= cfg_wdata;
                REG_DIALOG_BLOCK:  dialog_block_reg  <= cfg_wdata[7:0];
                REG_REPORT_EVERY:  report_every_reg  <= cfg_wdata[3:0];
                REG_NORMAL_PERIOD: normal_period_reg <= cfg_wdata[7:0];
                REG_WARN_PERIOD:   warn_period_reg   <= cfg_wdata[7:0];
                REG_FREEZE_PERIOD: freeze_period_reg <= cfg_wdata[7:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ping_reg          <= '0;
            beat_reg          <= '0;
            state_reg         <= ST_NORMAL;
            freeze_checks_reg <= 4'd0;
            allowed_reg       <= 1'b1;
            block_cnt_reg     <= 8'd0;
            head_reg          <= '0;
            fill_reg          <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            ping_reg          <= ping_next;
            beat_reg          <= beat_next;
            state_reg         <= state_next;
            freeze_checks_reg <= freeze_checks_next;
            allowed_reg       <= allowed_next;
            block_cnt_reg     <= block_cnt_next;
            head_reg          <= head_next;
            fill_reg          <= fill_next;
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_result_reg <= res;
        end
    end

    // The head register always holds the entry at the next head, with a
    // bypass for a write into that same entry.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            stamp_mem[tail_addr] <= q_item.arg;
        end
        if (mem_we && (tail_addr == head_next))
        begin
            head_data_reg <= q_item.arg;
        end
        else
        begin
            head_data_reg <= stamp_mem[head_next];
        end
    end

`ifndef SYNTH
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= DEPTH_F)
        else $error("timestamp FIFO fill above depth");
    a_tick_pings: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && q_item.op == OP_TICK) |=> out_valid_reg && out_result_reg.ping_thread)
        else $error("check tick gave no ping request");
    a_dialog_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && res.show_dialog) |=> !allowed_reg && block_cnt_reg == 8'd0)
        else $error("dialog shown without blocking the next one");
    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && res.bomb_dropped) |-> fill_reg == DEPTH_F)
        else $error("bury dropped while FIFO had room");
`endif

endmodule

[rtl/thread_stall_watchdog.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thread_stall_watchdog: liveness watchdog for one watched thread
// Counts pings and heartbeats, escalates through warning and freeze, and
// tests the oldest pending input timestamp while the thread is stalled.
// ----------------------------------------------------------------------------
// Usage:
// Input beats arrive on the s_axis channel; s_axis_tuser carries the
// operation (check tick, heartbeat, bury timestamp, defuse oldest) and
// s_axis_tdata the bury timestamp and the current time. Every accepted beat
// gives exactly one result beat on m_axis.
// Registers are to be written by the user through cfg_wr_en, cfg_index and
// cfg_wdata only while the block is idle; the block does not enforce this.
// An accepted beat is registered in the item queue, and its result is then
// registered in the result register once that register is free.
// Throughput is one beat per cycle while results are taken, set by the back end
// that executes one operation per cycle against the state and timestamp memory.
// While m_axis_tready is low the result register holds its beat and the
// two-entry queue takes input until it is full; then s_axis_tready drops.
// Reset clears the counters, the watch state and the FIFO pointers and loads
// the register defaults; no clearing pass runs.
// ----------------------------------------------------------------------------
module thread_stall_watchdog
    import tsw_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,  // bomb_stamp_ms[63:0], now_ms[127:64]
    input  logic [S_TUSER_W-1:0] s_axis_tuser,  // func[1:0]
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata   // report[1:0], show_dialog[2],
                                                // ping_thread[3], next_period_s[11:4],
                                                // stuck[12], bomb_dropped[13]
);

    logic    q_valid;
    item_t   q_item;
    logic    q_pop;
    result_t out_result;

    tsw_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .func          (s_axis_tuser),
        .bomb_stamp_ms (s_axis_tdata[63:0]),
        .now_ms        (s_axis_tdata[127:64]),
        .in_valid      (s_axis_tvalid),
        .in_ready      (s_axis_tready),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop)
    );

    tsw_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_result (out_result)
    );

    assign m_axis_tdata = {2'b00,
                           out_result.bomb_dropped,
                           out_result.stuck,
                           out_result.next_period_s,
                           out_result.ping_thread,
                           out_result.show_dialog,
                           out_result.report};

endmodule
